@@ sv/vna_pkg.sv @@
// Shared types and constants for the vertex normal accumulator.
// Used by the controller, the datapath and the top level.
package vna_pkg;

   localparam int SUM_BITS   = 51;
   localparam int CNT_BITS   = 16;
   localparam int NORM_BITS  = 36;
   localparam int INDEX_BITS = 10;
   localparam int DIV_BITS   = 6;
   localparam logic [CNT_BITS-1:0] COUNT_MAX = 16'hFFFF;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_FACE  = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   localparam logic [1:0] SEL_A = 2'd0;
   localparam logic [1:0] SEL_B = 2'd1;
   localparam logic [1:0] SEL_C = 2'd2;
   localparam logic [1:0] SEL_V = 2'd3;

   localparam logic [1:0] RK_ZERO   = 2'd0;
   localparam logic [1:0] RK_NOFACE = 2'd1;
   localparam logic [1:0] RK_NORMAL = 2'd2;

   typedef struct packed {
      logic [SUM_BITS-1:0] sum_x;
      logic [SUM_BITS-1:0] sum_y;
      logic [SUM_BITS-1:0] sum_z;
      logic [CNT_BITS-1:0] count;
   } acc_type;

   typedef struct packed {
      logic       capture;
      logic       pos_wr;
      logic       pos_rd;
      logic [1:0] rd_sel;
      logic       pos_ld;
      logic [1:0] ld_sel;
      logic       diff_ld;
      logic       mul_en;
      logic [2:0] mul_sel;
      logic       n_ld;
      logic [2:0] n_sel;
      logic       acc_rd;
      logic       acc_wr;
      logic [1:0] acc_sel;
      logic       acc_zero;
      logic       sweep_clr;
      logic       sweep_inc;
      logic       div_init;
      logic       div_step;
      logic       rsp_load;
      logic [1:0] rsp_kind;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       idx_ok;
      logic       face_ok;
      logic       b_dup;
      logic       c_dup;
      logic       cnt_sat;
      logic       cnt_zero;
      logic       sweep_last;
      logic       div_last;
   } status_type;

endpackage

@@ sv/vna_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vna_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/vna_ctrl.sv @@
// Sequencing state machine for the vertex normal accumulator.
// Depends on vna_pkg; drives vna_datapath through cmd_type.
module vna_ctrl
   import vna_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [3:0] S_SWEEP  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_DECODE = 4'd2;
   localparam logic [3:0] S_PRD    = 4'd3;
   localparam logic [3:0] S_MUL    = 4'd4;
   localparam logic [3:0] S_ACCRD  = 4'd5;
   localparam logic [3:0] S_ACCWR  = 4'd6;
   localparam logic [3:0] S_QRD    = 4'd7;
   localparam logic [3:0] S_QWAIT  = 4'd8;
   localparam logic [3:0] S_DIV    = 4'd9;
   localparam logic [3:0] S_FINISH = 4'd10;

   logic [3:0] state_ff, state_in;
   logic [2:0] step_ff, step_in;
   logic [1:0] kind_ff, kind_in;
   logic       clr_ff, clr_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       skip;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         step_ff      <= '0;
         kind_ff      <= RK_ZERO;
         clr_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         kind_ff      <= kind_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign skip = (step_ff[1:0] == SEL_B && status.b_dup) ||
                 (step_ff[1:0] == SEL_C && status.c_dup);

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      kind_in      = kind_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      req_ready    = 1'b0;
      case (state_ff)
         S_SWEEP: begin
            cmd.acc_wr    = 1'b1;
            cmd.acc_zero  = 1'b1;
            cmd.sweep_inc = 1'b1;
            if (status.sweep_last) begin
               cmd.sweep_clr = 1'b1;
               clr_in        = 1'b0;
               state_in      = clr_ff ? S_FINISH : S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            kind_in = RK_ZERO;
            step_in = '0;
            case (status.op)
               OP_WRITE: begin
                  cmd.pos_wr = status.idx_ok;
                  state_in   = S_FINISH;
               end
               OP_FACE: begin
                  state_in = status.face_ok ? S_PRD : S_FINISH;
               end
               OP_READ: begin
                  if (status.idx_ok) begin
                     state_in = S_QRD;
                  end else begin
                     kind_in  = RK_NOFACE;
                     state_in = S_FINISH;
                  end
               end
               default: begin
                  clr_in   = 1'b1;
                  state_in = S_SWEEP;
               end
            endcase
         end
         S_PRD: begin
            cmd.pos_rd = (step_ff != 3'd3);
            cmd.rd_sel = step_ff[1:0];
            cmd.pos_ld = (step_ff != 3'd0);
            cmd.ld_sel = 2'(step_ff - 3'd1);
            step_in    = step_ff + 3'd1;
            if (step_ff == 3'd3) begin
               step_in  = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.diff_ld = (step_ff == 3'd0);
            cmd.mul_en  = (step_ff != 3'd0) && (step_ff != 3'd7);
            cmd.mul_sel = step_ff - 3'd1;
            cmd.n_ld    = (step_ff >= 3'd2);
            cmd.n_sel   = step_ff - 3'd2;
            step_in     = step_ff + 3'd1;
            if (step_ff == 3'd7) begin
               step_in  = '0;
               state_in = S_ACCRD;
            end
         end
         S_ACCRD: begin
            cmd.acc_sel = step_ff[1:0];
            if (skip) begin
               step_in = step_ff + 3'd1;
               if (step_ff[1:0] == SEL_C) begin
                  state_in = S_FINISH;
               end
            end else begin
               cmd.acc_rd = 1'b1;
               state_in   = S_ACCWR;
            end
         end
         S_ACCWR: begin
            cmd.acc_sel = step_ff[1:0];
            cmd.acc_wr  = !status.cnt_sat;
            step_in     = step_ff + 3'd1;
            state_in    = (step_ff[1:0] == SEL_C) ? S_FINISH : S_ACCRD;
         end
         S_QRD: begin
            cmd.acc_rd  = 1'b1;
            cmd.acc_sel = SEL_V;
            state_in    = S_QWAIT;
         end
         S_QWAIT: begin
            cmd.div_init = 1'b1;
            if (status.cnt_zero) begin
               kind_in  = RK_NOFACE;
               state_in = S_FINISH;
            end else begin
               kind_in  = RK_NORMAL;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_kind = kind_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ sv/vna_datapath.sv @@
// Request registers, position and accumulator RAMs, cross product and divider lanes.
// Depends on vna_pkg and vna_ram; steered by vna_ctrl.
module vna_datapath
   import vna_pkg::*;
#(
   parameter int VERTEX_SLOTS = 1024,
   parameter int COORD_BITS   = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cmd_type                     cmd,
   output status_type                  status,
   input  logic [1:0]                  req_operation,
   input  logic [INDEX_BITS-1:0]       req_vertex_index,
   input  logic signed [15:0]          req_pos_x,
   input  logic signed [15:0]          req_pos_y,
   input  logic signed [15:0]          req_pos_z,
   input  logic [INDEX_BITS-1:0]       req_corner_a,
   input  logic [INDEX_BITS-1:0]       req_corner_b,
   input  logic [INDEX_BITS-1:0]       req_corner_c,
   output logic signed [NORM_BITS-1:0] rsp_normal_x,
   output logic signed [NORM_BITS-1:0] rsp_normal_y,
   output logic signed [NORM_BITS-1:0] rsp_normal_z,
   output logic [CNT_BITS-1:0]         rsp_face_count,
   output logic                        rsp_no_faces
);

   localparam int AW  = $clog2(VERTEX_SLOTS);
   localparam int C   = COORD_BITS;
   localparam int DW  = C + 1;
   localparam int PW  = 2 * DW;
   localparam int NW  = PW + 1;
   localparam int PSW = 3 * C;

   logic [1:0]            op_ff;
   logic [INDEX_BITS-1:0] idx_ff, ca_ff, cb_ff, cc_ff;
   logic [15:0]           px_ff, py_ff, pz_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_operation;
         idx_ff <= req_vertex_index;
         px_ff  <= req_pos_x;
         py_ff  <= req_pos_y;
         pz_ff  <= req_pos_z;
         ca_ff  <= req_corner_a;
         cb_ff  <= req_corner_b;
         cc_ff  <= req_corner_c;
      end
   end

   function automatic logic [AW-1:0] to_addr(input logic [INDEX_BITS-1:0] idx);
      logic [16:0] w;
      w = {7'b0, idx};
      return w[AW-1:0];
   endfunction

   function automatic logic in_range(input logic [INDEX_BITS-1:0] idx);
      return {7'b0, idx} < 17'(VERTEX_SLOTS);
   endfunction

   function automatic logic [C-1:0] coord(input logic [15:0] v);
      logic [23:0] w;
      w = {8'b0, v};
      return w[C-1:0];
   endfunction

   logic [INDEX_BITS-1:0] rd_corner, acc_corner;

   always_comb begin
      case (cmd.rd_sel)
         SEL_A:   rd_corner = ca_ff;
         SEL_B:   rd_corner = cb_ff;
         default: rd_corner = cc_ff;
      endcase
      case (cmd.acc_sel)
         SEL_A:   acc_corner = ca_ff;
         SEL_B:   acc_corner = cb_ff;
         SEL_C:   acc_corner = cc_ff;
         default: acc_corner = idx_ff;
      endcase
   end

   // position store
   logic [PSW-1:0] pos_rd_data;

   vna_ram #(.WIDTH(PSW), .DEPTH(VERTEX_SLOTS)) u_pos_ram (
      .clock   (clock),
      .wr_en   (cmd.pos_wr),
      .wr_addr (to_addr(idx_ff)),
      .wr_data ({coord(px_ff), coord(py_ff), coord(pz_ff)}),
      .rd_en   (cmd.pos_rd),
      .rd_addr (to_addr(rd_corner)),
      .rd_data (pos_rd_data)
   );

   logic [C-1:0] pa_ff [3];
   logic [C-1:0] pb_ff [3];
   logic [C-1:0] pc_ff [3];
   logic signed [DW-1:0] f_ff [3];
   logic signed [DW-1:0] g_ff [3];
   logic signed [PW-1:0] prod_ff;
   logic signed [NW-1:0] n_ff [3];
   logic signed [DW-1:0] m1, m2;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (cmd.pos_ld && cmd.ld_sel == SEL_A) pa_ff[i] <= pos_rd_data[(2-i)*C +: C];
         if (cmd.pos_ld && cmd.ld_sel == SEL_B) pb_ff[i] <= pos_rd_data[(2-i)*C +: C];
         if (cmd.pos_ld && cmd.ld_sel == SEL_C) pc_ff[i] <= pos_rd_data[(2-i)*C +: C];
         if (cmd.diff_ld) begin
            f_ff[i] <= {pb_ff[i][C-1], pb_ff[i]} - {pa_ff[i][C-1], pa_ff[i]};
            g_ff[i] <= {pc_ff[i][C-1], pc_ff[i]} - {pa_ff[i][C-1], pa_ff[i]};
         end
      end
      if (cmd.mul_en) begin
         prod_ff <= m1 * m2;
      end
      if (cmd.n_ld) begin
         if (cmd.n_sel[0]) begin
            n_ff[cmd.n_sel[2:1]] <= n_ff[cmd.n_sel[2:1]] - NW'(prod_ff);
         end else begin
            n_ff[cmd.n_sel[2:1]] <= NW'(prod_ff);
         end
      end
   end

   always_comb begin
      case (cmd.mul_sel)
         3'd0:    begin m1 = f_ff[1]; m2 = g_ff[2]; end
         3'd1:    begin m1 = f_ff[2]; m2 = g_ff[1]; end
         3'd2:    begin m1 = f_ff[2]; m2 = g_ff[0]; end
         3'd3:    begin m1 = f_ff[0]; m2 = g_ff[2]; end
         3'd4:    begin m1 = f_ff[0]; m2 = g_ff[1]; end
         default: begin m1 = f_ff[1]; m2 = g_ff[0]; end
      endcase
   end

   // accumulator store
   logic [AW-1:0]  sweep_ff;
   acc_type        acc_rd_data, acc_wr_data;
   logic [AW-1:0]  acc_wr_addr;
   logic signed [SUM_BITS-1:0] n_ext [3];

   always_ff @(posedge clock) begin
      if (reset || cmd.sweep_clr) begin
         sweep_ff <= '0;
      end else if (cmd.sweep_inc) begin
         sweep_ff <= sweep_ff + AW'(1);
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n_ext[i] = SUM_BITS'(n_ff[i]);
      end
      acc_wr_addr = cmd.acc_zero ? sweep_ff : to_addr(acc_corner);
      if (cmd.acc_zero) begin
         acc_wr_data = '0;
      end else begin
         acc_wr_data.sum_x = acc_rd_data.sum_x + n_ext[0];
         acc_wr_data.sum_y = acc_rd_data.sum_y + n_ext[1];
         acc_wr_data.sum_z = acc_rd_data.sum_z + n_ext[2];
         acc_wr_data.count = acc_rd_data.count + CNT_BITS'(1);
      end
   end

   vna_ram #(.WIDTH($bits(acc_type)), .DEPTH(VERTEX_SLOTS)) u_acc_ram (
      .clock   (clock),
      .wr_en   (cmd.acc_wr),
      .wr_addr (acc_wr_addr),
      .wr_data (acc_wr_data),
      .rd_en   (cmd.acc_rd),
      .rd_addr (to_addr(acc_corner)),
      .rd_data (acc_rd_data)
   );

   // divider lanes, restoring, one quotient bit per cycle
   logic [SUM_BITS-1:0] mag_ff [3];
   logic [CNT_BITS-1:0] rem_ff [3];
   logic                neg_ff [3];
   logic [CNT_BITS-1:0] cnt_ff;
   logic [DIV_BITS-1:0] div_ff;
   logic [SUM_BITS-1:0] sum_sel [3];
   logic [CNT_BITS:0]   shifted [3];
   logic                ge [3];
   logic [SUM_BITS-1:0] quot [3];

   always_comb begin
      sum_sel[0] = acc_rd_data.sum_x;
      sum_sel[1] = acc_rd_data.sum_y;
      sum_sel[2] = acc_rd_data.sum_z;
      for (int i = 0; i < 3; i++) begin
         shifted[i] = {rem_ff[i], mag_ff[i][SUM_BITS-1]};
         ge[i]      = shifted[i] >= {1'b0, cnt_ff};
         quot[i]    = neg_ff[i] ? -mag_ff[i] : mag_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         cnt_ff <= acc_rd_data.count;
         div_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            neg_ff[i] <= sum_sel[i][SUM_BITS-1];
            mag_ff[i] <= sum_sel[i][SUM_BITS-1] ? -sum_sel[i] : sum_sel[i];
            rem_ff[i] <= '0;
         end
      end else if (cmd.div_step) begin
         div_ff <= div_ff + DIV_BITS'(1);
         for (int i = 0; i < 3; i++) begin
            rem_ff[i] <= ge[i] ? CNT_BITS'(shifted[i] - {1'b0, cnt_ff})
                               : shifted[i][CNT_BITS-1:0];
            mag_ff[i] <= {mag_ff[i][SUM_BITS-2:0], ge[i]};
         end
      end
   end

   // response registers
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         case (cmd.rsp_kind)
            RK_NORMAL: begin
               rsp_normal_x   <= quot[0][NORM_BITS-1:0];
               rsp_normal_y   <= quot[1][NORM_BITS-1:0];
               rsp_normal_z   <= quot[2][NORM_BITS-1:0];
               rsp_face_count <= cnt_ff;
               rsp_no_faces   <= 1'b0;
            end
            RK_NOFACE: begin
               rsp_normal_x   <= '0;
               rsp_normal_y   <= '0;
               rsp_normal_z   <= '0;
               rsp_face_count <= '0;
               rsp_no_faces   <= 1'b1;
            end
            default: begin
               rsp_normal_x   <= '0;
               rsp_normal_y   <= '0;
               rsp_normal_z   <= '0;
               rsp_face_count <= '0;
               rsp_no_faces   <= 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      status.op         = op_ff;
      status.idx_ok     = in_range(idx_ff);
      status.face_ok    = in_range(ca_ff) && in_range(cb_ff) && in_range(cc_ff);
      status.b_dup      = (cb_ff == ca_ff);
      status.c_dup      = (cc_ff == ca_ff) || (cc_ff == cb_ff);
      status.cnt_sat    = (acc_rd_data.count == COUNT_MAX);
      status.cnt_zero   = (acc_rd_data.count == '0);
      status.sweep_last = (sweep_ff == AW'(VERTEX_SLOTS - 1));
      status.div_last   = (div_ff == DIV_BITS'(SUM_BITS - 1));
   end

endmodule

@@ sv/vertex_normal_accumulator.sv @@
// Top level of the vertex normal accumulator: controller plus datapath.
// Depends on vna_pkg, vna_ctrl, vna_datapath (and vna_ram below it).
//
//  channel  direction  handshake               payload
//  req_     in         req_valid / req_ready   operation, vertex_index, pos_x/y/z, corner_a/b/c
//  rsp_     out        rsp_valid / rsp_ready   normal_x/y/z, face_count, no_faces
//
// Work per request: add face does three position reads,
// six products through one multiplier, a read-modify-write per distinct corner;
// read normal runs a 51-step restoring divide in three lanes, skipped when the count is zero;
// clear zeroes all VERTEX_SLOTS entries of the accumulator RAM.
// After reset a pass over all VERTEX_SLOTS entries zeroes the accumulator RAM; req_ready
// stays low meanwhile. One request is in work at a time; the response register
// lets a new request be taken while the last response waits on rsp_ready.
module vertex_normal_accumulator
   import vna_pkg::*;
#(
   parameter int VERTEX_SLOTS = 1024,
   parameter int COORD_BITS   = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_operation,
   input  logic [INDEX_BITS-1:0]       req_vertex_index,
   input  logic signed [15:0]          req_pos_x,
   input  logic signed [15:0]          req_pos_y,
   input  logic signed [15:0]          req_pos_z,
   input  logic [INDEX_BITS-1:0]       req_corner_a,
   input  logic [INDEX_BITS-1:0]       req_corner_b,
   input  logic [INDEX_BITS-1:0]       req_corner_c,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [NORM_BITS-1:0] rsp_normal_x,
   output logic signed [NORM_BITS-1:0] rsp_normal_y,
   output logic signed [NORM_BITS-1:0] rsp_normal_z,
   output logic [CNT_BITS-1:0]         rsp_face_count,
   output logic                        rsp_no_faces
);

   cmd_type    cmd;
   status_type status;

   vna_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   vna_datapath #(
      .VERTEX_SLOTS (VERTEX_SLOTS),
      .COORD_BITS   (COORD_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_operation    (req_operation),
      .req_vertex_index (req_vertex_index),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .req_corner_a     (req_corner_a),
      .req_corner_b     (req_corner_b),
      .req_corner_c     (req_corner_c),
      .rsp_normal_x     (rsp_normal_x),
      .rsp_normal_y     (rsp_normal_y),
      .rsp_normal_z     (rsp_normal_z),
      .rsp_face_count   (rsp_face_count),
      .rsp_no_faces     (rsp_no_faces)
   );

   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while another is in work");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response raised without a finishing cycle");

   a_no_rsp_from_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !cmd.rsp_load)
      else $error("response loaded right after accept");

endmodule
